>>> design/rpud_pkg.sv
`default_nettype none
package rpud_pkg;

	localparam int MAX_LEB_BYTES_DEF = 10;

	// descriptor kinds
	typedef enum logic [2:0] {
		CMD_WHEN   = 3'd0,
		CMD_GR     = 3'd1,
		CMD_BR     = 3'd2,
		CMD_PSPREL = 3'd3,
		CMD_SPREL  = 3'd4
	} cmd_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_TIME = 2'd1,
		STAT_REG  = 2'd2,
		STAT_LONG = 2'd3
	} stat_t;

	// header and register bytes
	localparam logic [7:0] HDR_WHEN   = 8'hE4;
	localparam logic [7:0] HDR_GR     = 8'hB0;
	localparam logic [7:0] HDR_BR     = 8'hB3;
	localparam logic [7:0] HDR_PSPREL = 8'hE5;
	localparam logic [7:0] HDR_SPREL  = 8'hF0;
	localparam logic [7:0] HDR_SPREL2 = 8'h01;
	localparam logic [7:0] GR_MARK    = 8'h80;
	localparam logic [7:0] BR_MARK    = 8'h00;
	localparam logic [63:0] REG_LIMIT = 64'd128;

	// which byte the datapath puts into the output register
	typedef enum logic [2:0] {
		SEL_ERR  = 3'd0,
		SEL_HDR0 = 3'd1,
		SEL_HDR1 = 3'd2,
		SEL_REG  = 3'd3,
		SEL_LEB  = 3'd4
	} sel_t;

	typedef enum logic [2:0] {
		S_IDLE  = 3'd0,
		S_CHECK = 3'd1,
		S_REG   = 3'd2,
		S_HDR1  = 3'd3,
		S_LEB   = 3'd4
	} state_t;

	typedef struct packed {
		logic load;   // latch command and value
		logic emit;   // write one byte to the output register
		sel_t sel;
	} ctrl_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       cmd_ok;    // command is a known kind
		logic       err;       // item ends in an error result
		logic       leb_fin;   // current LEB128 byte is the last
		logic       out_free;  // output register can take a byte now
	} dp_stat_t;

endpackage
`default_nettype wire

>>> design/rpud_ctrl.sv
`default_nettype none
module rpud_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  rpud_pkg::dp_stat_t  dp_stat,
	output rpud_pkg::ctrl_t     ctrl
);
	import rpud_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		in_ready  = 1'b0;
		ctrl.load = 1'b0;
		ctrl.emit = 1'b0;
		ctrl.sel  = SEL_ERR;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.load = 1'b1;
					state_nx  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!dp_stat.cmd_ok) begin
					state_nx = S_IDLE;   // unknown kind: no result
				end else if (dp_stat.out_free) begin
					ctrl.emit = 1'b1;
					if (dp_stat.err) begin
						ctrl.sel = SEL_ERR;
						state_nx = S_IDLE;
					end else begin
						ctrl.sel = SEL_HDR0;
						if (dp_stat.cmd == CMD_GR || dp_stat.cmd == CMD_BR) begin
							state_nx = S_REG;
						end else if (dp_stat.cmd == CMD_SPREL) begin
							state_nx = S_HDR1;
						end else begin
							state_nx = S_LEB;
						end
					end
				end
			end
			S_REG: begin
				if (dp_stat.out_free) begin
					ctrl.emit = 1'b1;
					ctrl.sel  = SEL_REG;
					state_nx  = S_IDLE;
				end
			end
			S_HDR1: begin
				if (dp_stat.out_free) begin
					ctrl.emit = 1'b1;
					ctrl.sel  = SEL_HDR1;
					state_nx  = S_LEB;
				end
			end
			S_LEB: begin
				if (dp_stat.out_free) begin
					ctrl.emit = 1'b1;
					ctrl.sel  = SEL_LEB;
					if (dp_stat.leb_fin) begin
						state_nx = S_IDLE;
					end
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> design/rpud_dp.sv
`default_nettype none
module rpud_dp #(
	parameter int MAX_LEB_BYTES = rpud_pkg::MAX_LEB_BYTES_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_valid,
	input  wire  [63:0]         cfg_data,
	input  wire  [2:0]          command,
	input  wire  [63:0]         value,
	input  rpud_pkg::ctrl_t     ctrl,
	output rpud_pkg::dp_stat_t  dp_stat,
	input  wire                 out_ready,
	output logic                out_valid,
	output logic [7:0]          out_byte,
	output logic                last,
	output logic [1:0]          status
);
	import rpud_pkg::*;

	localparam int LEB_BITS = 7 * MAX_LEB_BYTES;

	logic [63:0] region_q;
	logic [2:0]  cmd_q;
	logic [63:0] val_q;
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [1:0]  stat_q;

	logic        too_long;
	stat_t       err_code;
	logic        err;
	logic        cmd_ok;
	logic        leb_fin;
	logic [7:0]  hdr0;
	logic [7:0]  nx_byte;
	logic        nx_last;
	logic [1:0]  nx_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= '0;
		end else if (cfg_valid) begin
			region_q <= cfg_data;
		end
	end

	// remaining value bits beyond what the byte bound can carry
	assign too_long = |(val_q >> LEB_BITS);
	assign leb_fin  = (val_q[63:7] == '0);

	always_comb begin
		err      = 1'b0;
		err_code = STAT_OK;
		cmd_ok   = 1'b1;
		hdr0     = HDR_WHEN;
		unique case (cmd_q)
			CMD_WHEN: begin
				hdr0 = HDR_WHEN;
				if (val_q >= region_q) begin
					err      = 1'b1;
					err_code = STAT_TIME;
				end else if (too_long) begin
					err      = 1'b1;
					err_code = STAT_LONG;
				end
			end
			CMD_GR, CMD_BR: begin
				hdr0 = (cmd_q == CMD_GR) ? HDR_GR : HDR_BR;
				if (val_q >= REG_LIMIT) begin
					err      = 1'b1;
					err_code = STAT_REG;
				end
			end
			CMD_PSPREL, CMD_SPREL: begin
				hdr0 = (cmd_q == CMD_PSPREL) ? HDR_PSPREL : HDR_SPREL;
				if (too_long) begin
					err      = 1'b1;
					err_code = STAT_LONG;
				end
			end
			default: begin
				cmd_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		nx_byte = 8'h00;
		nx_last = 1'b0;
		nx_stat = STAT_OK;
		unique case (ctrl.sel)
			SEL_ERR: begin
				nx_last = 1'b1;
				nx_stat = err_code;
			end
			SEL_HDR0: nx_byte = hdr0;
			SEL_HDR1: nx_byte = HDR_SPREL2;
			SEL_REG: begin
				nx_byte = ((cmd_q == CMD_GR) ? GR_MARK : BR_MARK) | {1'b0, val_q[6:0]};
				nx_last = 1'b1;
			end
			SEL_LEB: begin
				nx_byte = {~leb_fin, val_q[6:0]};
				nx_last = leb_fin;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= command;
			val_q <= value;
		end else if (ctrl.emit && ctrl.sel == SEL_LEB) begin
			val_q <= val_q >> 7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			byte_q <= nx_byte;
			last_q <= nx_last;
			stat_q <= nx_stat;
		end
	end

	assign dp_stat.cmd      = cmd_q;
	assign dp_stat.cmd_ok   = cmd_ok;
	assign dp_stat.err      = err;
	assign dp_stat.leb_fin  = leb_fin;
	assign dp_stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_byte  = byte_q;
	assign last      = last_q;
	assign status    = stat_q;

endmodule
`default_nettype wire

>>> design/return_pointer_unwind_descriptor_encoder.sv
// Return-pointer unwind descriptor encoder. Each input item (command, value)
// turns into the byte stream of one descriptor, one output item per byte:
// when = E4 + ULEB128(value), gr = B0 + (80|reg), br = B3 + reg,
// psprel = E5 + ULEB128(value), sprel = F0 01 + ULEB128(value). The final
// byte carries last=1. A "when" at or beyond region_size, a register of 128
// or more, or a ULEB128 longer than MAX_LEB_BYTES gives a single output item
// instead: out_byte 0, last 1, status 1/2/3. Commands 5..7 give no output.
// region_size is written through the cfg port (reset 0); the user must write it
// only while the block is idle, as the block itself does not enforce it. An
// item is accepted in the idle state; the check state then sends the first
// byte or the error item, and each further byte comes from the register,
// second-header or LEB128 state. The rate is set by the single output register,
// which moves one byte per cycle while out_ready is high, and by the controller
// taking one item at a time. Output stalls simply hold the controller in place.
`default_nettype none
module return_pointer_unwind_descriptor_encoder #(
	parameter int MAX_LEB_BYTES = rpud_pkg::MAX_LEB_BYTES_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	// configuration: region_size
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [63:0] cfg_data,
	// input items
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [2:0]  command,
	input  wire  [63:0] value,
	// output items, one per descriptor byte
	output logic        out_valid,
	input  wire         out_ready,
	output logic [7:0]  out_byte,
	output logic        last,
	output logic [1:0]  status
);
	import rpud_pkg::*;

	ctrl_t    ctrl;
	dp_stat_t dp_stat;

	// register writes are registered and always taken
	assign cfg_ready = 1'b1;

	// sequencer: check, headers, register byte, LEB128 bytes
	rpud_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.dp_stat  (dp_stat),
		.ctrl     (ctrl)
	);

	// item registers, error checks, byte mux, output register
	rpud_dp #(
		.MAX_LEB_BYTES (MAX_LEB_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.command   (command),
		.value     (value),
		.ctrl      (ctrl),
		.dp_stat   (dp_stat),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.last      (last),
		.status    (status)
	);

endmodule
`default_nettype wire
